// ===== design/lzx_pkg.sv =====
// Shared types, constants and code tables for the explode decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzx_pkg;

  localparam int BUF_W        = 40;
  localparam int CNT_W        = 6;
  localparam int BEAT_N       = 16;
  localparam int FILL_W       = 5;
  localparam int LEN_W        = 10;
  localparam int DIST_W       = 13;
  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam logic [LEN_W-1:0] END_LEN = 10'd519;

  typedef enum logic [2:0] {
    TK_NEED = 3'd0,
    TK_LIT  = 3'd1,
    TK_COPY = 3'd2,
    TK_END  = 3'd3,
    TK_ERR  = 3'd4
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [7:0]             lit;
    logic [LEN_W-1:0]       len;
    logic [DIST_W-1:0]      distance;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } match_t;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] base;
    logic [3:0]       extra;
  } len_pfx_t;

  localparam logic [7:0] LIT_ROM [256] = '{
    8'h20, 8'h45, 8'h61, 8'h65, 8'h69, 8'h6c, 8'h6e, 8'h6f, 8'h72, 8'h73, 8'h74, 8'h75,
    8'h2d, 8'h31, 8'h41, 8'h43, 8'h44, 8'h49, 8'h4c, 8'h4e, 8'h4f, 8'h52, 8'h53, 8'h54,
    8'h62, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6d, 8'h70, 8'h0a, 8'h0d, 8'h28, 8'h29,
    8'h2c, 8'h2e, 8'h30, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37, 8'h38, 8'h3d, 8'h42, 8'h46,
    8'h4d, 8'h50, 8'h55, 8'h6b, 8'h77, 8'h09, 8'h22, 8'h27, 8'h2a, 8'h2f, 8'h36, 8'h39,
    8'h3a, 8'h47, 8'h48, 8'h57, 8'h5b, 8'h5f, 8'h76, 8'h78, 8'h79, 8'h2b, 8'h3e, 8'h4b,
    8'h56, 8'h58, 8'h59, 8'h5d, 8'h21, 8'h24, 8'h26, 8'h71, 8'h7a, 8'h00, 8'h3c, 8'h3f,
    8'h4a, 8'h51, 8'h5a, 8'h5c, 8'h6a, 8'h7b, 8'h7c, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
    8'h06, 8'h07, 8'h08, 8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f, 8'h23, 8'h25,
    8'h3b, 8'h40, 8'h5e, 8'h60, 8'h7d, 8'h7e, 8'h7f, 8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4,
    8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hc0,
    8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc,
    8'hcd, 8'hce, 8'hcf, 8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8,
    8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde, 8'hdf, 8'he1, 8'he5, 8'he9, 8'hee, 8'hf2,
    8'hf3, 8'hf4, 8'h1a, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88,
    8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94,
    8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f, 8'ha0,
    8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac,
    8'had, 8'hae, 8'haf, 8'he0, 8'he2, 8'he3, 8'he4, 8'he6, 8'he7, 8'he8, 8'hea, 8'heb,
    8'hec, 8'hed, 8'hef, 8'hf0, 8'hf1, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb,
    8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  // literal prefix code rows 4..13
  function automatic match_t lit_match(input logic [12:0] bits, input logic [3:0] n);
    logic [12:0] code;
    logic [7:0]  cnt;
    logic [8:0]  val;
    logic [12:0] diff;
    match_t      m;
    case (n)
      4'd4:    begin code = 13'h0F; cnt = 8'd1;  val = 9'd0;   end
      4'd5:    begin code = 13'h13; cnt = 8'd11; val = 9'd11;  end
      4'd6:    begin code = 13'h12; cnt = 8'd20; val = 9'd31;  end
      4'd7:    begin code = 13'h0F; cnt = 8'd21; val = 9'd52;  end
      4'd8:    begin code = 13'h0E; cnt = 8'd16; val = 9'd68;  end
      4'd9:    begin code = 13'h15; cnt = 8'd7;  val = 9'd75;  end
      4'd10:   begin code = 13'h25; cnt = 8'd5;  val = 9'd80;  end
      4'd11:   begin code = 13'h40; cnt = 8'd10; val = 9'd90;  end
      4'd12:   begin code = 13'h25; cnt = 8'd91; val = 9'd181; end
      4'd13:   begin code = 13'h00; cnt = 8'd74; val = 9'd255; end
      default: begin code = 13'h00; cnt = 8'd0;  val = 9'd0;   end
    endcase
    diff = bits - code;
    m.hit = (bits >= code) && (diff < {5'd0, cnt});
    m.value = 8'(val - diff[8:0]);
    return m;
  endfunction

  // offset prefix code rows 2 and 4..8
  function automatic match_t off_match(input logic [7:0] bits, input logic [3:0] n);
    logic [7:0] code;
    logic [7:0] cnt;
    logic [7:0] val;
    logic [7:0] diff;
    match_t     m;
    case (n)
      4'd2:    begin code = 8'h03; cnt = 8'd1;  val = 8'h00; end
      4'd4:    begin code = 8'h0A; cnt = 8'd2;  val = 8'h02; end
      4'd5:    begin code = 8'h10; cnt = 8'd4;  val = 8'h06; end
      4'd6:    begin code = 8'h11; cnt = 8'd15; val = 8'h15; end
      4'd7:    begin code = 8'h08; cnt = 8'd26; val = 8'h2F; end
      4'd8:    begin code = 8'h00; cnt = 8'd16; val = 8'h3F; end
      default: begin code = 8'h00; cnt = 8'd0;  val = 8'h00; end
    endcase
    diff = bits - code;
    m.hit = (bits >= code) && (diff < cnt);
    m.value = val - diff;
    return m;
  endfunction

  // length prefix tree, MSB-first prefix of n bits
  function automatic len_pfx_t len_prefix(input logic [6:0] p, input logic [2:0] n);
    len_pfx_t r;
    r = '0;
    case (n)
      3'd2: if (p == 7'd3) r = '{1'b1, 10'd3, 4'd0};
      3'd3: begin
        if (p == 7'd5) r = '{1'b1, 10'd2, 4'd0};
        if (p == 7'd4) r = '{1'b1, 10'd4, 4'd0};
        if (p == 7'd3) r = '{1'b1, 10'd5, 4'd0};
      end
      3'd4: begin
        if (p == 7'd5) r = '{1'b1, 10'd6, 4'd0};
        if (p == 7'd4) r = '{1'b1, 10'd7, 4'd0};
        if (p == 7'd3) r = '{1'b1, 10'd8, 4'd0};
      end
      3'd5: begin
        if (p == 7'd5) r = '{1'b1, 10'd9, 4'd0};
        if (p == 7'd4) r = '{1'b1, 10'd10, 4'd1};
        if (p == 7'd3) r = '{1'b1, 10'd12, 4'd2};
        if (p == 7'd2) r = '{1'b1, 10'd16, 4'd3};
      end
      3'd6: begin
        if (p == 7'd3) r = '{1'b1, 10'd24, 4'd4};
        if (p == 7'd2) r = '{1'b1, 10'd40, 4'd5};
        if (p == 7'd1) r = '{1'b1, 10'd72, 4'd6};
      end
      3'd7: begin
        if (p == 7'd1) r = '{1'b1, 10'd136, 4'd7};
        if (p == 7'd0) r = '{1'b1, 10'd264, 4'd8};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lzx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lzx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/lzx_token_dec.sv =====
// Bit-serial token parser: scans the bit buffer one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lzx_token_dec
  import lzx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [BUF_W-1:0] buf_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  input  wire logic             lmode_i,
  input  wire logic [2:0]       dbits_i,
  output logic                  done_o,
  output tok_t                  tok_o,
  output logic      [BUF_W-1:0] rem_buf_o,
  output logic      [CNT_W-1:0] rem_cnt_o
);

  typedef enum logic [7:0] {
    DS_IDLE  = 8'b0000_0001,
    DS_FLAG  = 8'b0000_0010,
    DS_RAW   = 8'b0000_0100,
    DS_LWALK = 8'b0000_1000,
    DS_LEN   = 8'b0001_0000,
    DS_LEXT  = 8'b0010_0000,
    DS_OWALK = 8'b0100_0000,
    DS_OLOW  = 8'b1000_0000
  } dstate_e;

  dstate_e          state_q, state_d;
  logic [BUF_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [12:0]      acc_q, acc_d;
  logic [3:0]       nb_q, nb_d;
  logic [7:0]       low_q, low_d;
  logic [3:0]       idx_q, idx_d;
  logic [3:0]       xtra_q, xtra_d;
  logic [LEN_W-1:0] base_q, base_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [5:0]       hi_q, hi_d;

  logic             bitv;
  logic [12:0]      acc_n;
  logic [3:0]       nb_n;
  logic [7:0]       low_n;
  logic [3:0]       idx_n;
  logic [3:0]       lb;
  logic [LEN_W-1:0] len_v;
  logic [11:0]      offs;
  match_t           lm, om;
  len_pfx_t         lp;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    nb_d    = nb_q;
    low_d   = low_q;
    idx_d   = idx_q;
    xtra_d  = xtra_q;
    base_d  = base_q;
    len_d   = len_q;
    hi_d    = hi_q;
    done_o  = 1'b0;
    tok_o   = '0;
    tok_o.kind = TK_NEED;

    bitv  = scan_q[0];
    acc_n = {acc_q[11:0], bitv};
    nb_n  = nb_q + 4'd1;
    low_n = low_q;
    low_n[idx_q[2:0]] = bitv;
    idx_n = idx_q + 4'd1;
    lm    = lit_match(acc_n, nb_n);
    om    = off_match(acc_n[7:0], nb_n);
    lp    = len_prefix(acc_n[6:0], nb_n[2:0]);
    lb    = (len_q == LEN_W'(2)) ? 4'd2 : {1'b0, dbits_i};
    len_v = base_q + LEN_W'(low_n);
    offs  = ({6'd0, hi_q} << lb) | {4'd0, low_n};

    if (start_i) begin
      scan_d  = buf_i;
      cnt_d   = cnt_i;
      state_d = DS_FLAG;
    end else if (state_q != DS_IDLE) begin
      if (cnt_q == '0) begin
        done_o  = 1'b1;
        state_d = DS_IDLE;
      end else begin
        scan_d = scan_q >> 1;
        cnt_d  = cnt_q - 1'b1;
        case (state_q)
          DS_FLAG: begin
            acc_d = '0;
            nb_d  = '0;
            low_d = '0;
            idx_d = '0;
            if (bitv) begin
              state_d = DS_LEN;
            end else if (lmode_i) begin
              state_d = DS_LWALK;
            end else begin
              state_d = DS_RAW;
            end
          end
          DS_RAW: begin
            low_d = low_n;
            idx_d = idx_n;
            if (idx_n == 4'd8) begin
              done_o     = 1'b1;
              tok_o.kind = TK_LIT;
              tok_o.lit  = low_n;
              state_d    = DS_IDLE;
            end
          end
          DS_LWALK: begin
            acc_d = acc_n;
            nb_d  = nb_n;
            if (nb_n >= 4'd4) begin
              if (lm.hit) begin
                done_o     = 1'b1;
                tok_o.kind = TK_LIT;
                tok_o.lit  = LIT_ROM[lm.value];
                state_d    = DS_IDLE;
              end else if (nb_n == 4'd13) begin
                done_o     = 1'b1;
                tok_o.kind = TK_ERR;
                state_d    = DS_IDLE;
              end
            end
          end
          DS_LEN: begin
            acc_d = acc_n;
            nb_d  = nb_n;
            if (lp.hit) begin
              base_d = lp.base;
              acc_d  = '0;
              nb_d   = '0;
              if (lp.extra == '0) begin
                len_d   = lp.base;
                state_d = DS_OWALK;
              end else begin
                xtra_d  = lp.extra;
                low_d   = '0;
                idx_d   = '0;
                state_d = DS_LEXT;
              end
            end
          end
          DS_LEXT: begin
            low_d = low_n;
            idx_d = idx_n;
            if (idx_n == xtra_q) begin
              if (len_v == END_LEN) begin
                done_o     = 1'b1;
                tok_o.kind = TK_END;
                state_d    = DS_IDLE;
              end else begin
                len_d   = len_v;
                state_d = DS_OWALK;
              end
            end
          end
          DS_OWALK: begin
            acc_d = acc_n;
            nb_d  = nb_n;
            if (nb_n >= 4'd2) begin
              if (om.hit) begin
                hi_d    = om.value[5:0];
                low_d   = '0;
                idx_d   = '0;
                state_d = DS_OLOW;
              end else if (nb_n == 4'd8) begin
                done_o     = 1'b1;
                tok_o.kind = TK_ERR;
                state_d    = DS_IDLE;
              end
            end
          end
          DS_OLOW: begin
            low_d = low_n;
            idx_d = idx_n;
            if (idx_n == lb) begin
              done_o         = 1'b1;
              tok_o.kind     = TK_COPY;
              tok_o.len      = len_q;
              tok_o.distance = {1'b0, offs} + 13'd1;
              state_d        = DS_IDLE;
            end
          end
          default: state_d = DS_IDLE;
        endcase
      end
    end
    rem_buf_o = scan_d;
    rem_cnt_o = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    nb_q   <= nb_d;
    low_q  <= low_d;
    idx_q  <= idx_d;
    xtra_q <= xtra_d;
    base_q <= base_d;
    len_q  <= len_d;
    hi_q   <= hi_d;
  end

endmodule
`default_nettype wire

// ===== design/lz_explode_decompressor.sv =====
// Explode decompressor top level: bit buffer, history window, beat assembly.
// Sequence: the accept, then the token parser scans the buffered bits one at a time; bits of
// an unfinished token are scanned again after the next byte. A literal passes through
// TS_LIT, a copy through TS_CRD and TS_CWR per replayed byte (window read then write);
// TS_FIN closes each input byte, and repeats when a full beat precedes an end or error flag.
// Input is taken one byte at a time.
// Reset clears control state; the history window is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lz_explode_decompressor
  import lzx_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  compressed_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] bytes_low_o,
  output logic      [63:0] bytes_high_o,
  output logic      [4:0]  byte_count_o,
  output logic             run_last_o,
  output logic             stream_end_o,
  output logic             code_error_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [2:0]  cfg_data_i
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int PW = AW + 1;

  typedef enum logic [5:0] {
    TS_IDLE = 6'b000001,
    TS_DEC  = 6'b000010,
    TS_LIT  = 6'b000100,
    TS_CRD  = 6'b001000,
    TS_CWR  = 6'b010000,
    TS_FIN  = 6'b100000
  } tstate_e;

  localparam logic [1:0] REG_LMODE = 2'd0;
  localparam logic [1:0] REG_DBITS = 2'd1;

  tstate_e           state_q, state_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  bcnt_q, bcnt_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic              fin_q, fin_d, fail_q, fail_d, end_q, end_d, err_q, err_d;
  logic              lmode_q, lmode_d;
  logic [2:0]        dbits_q, dbits_d;
  logic [7:0]        beat_q [BEAT_N];
  logic [7:0]        beat_d [BEAT_N];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [7:0]        lit_q, lit_d;
  logic              ovalid_q, ovalid_d;
  logic [63:0]       olow_q, olow_d, ohigh_q, ohigh_d;
  logic [4:0]        ocnt_q, ocnt_d;
  logic              olast_q, olast_d, oend_q, oend_d, oerr_q, oerr_d;

  logic              dec_start, dec_done;
  tok_t              dec_tok;
  logic [BUF_W-1:0]  dec_rem_buf;
  logic [CNT_W-1:0]  dec_rem_cnt;
  logic [2:0]        dclamp;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              out_free, can_push, push_en;
  logic [7:0]        push_byte;
  logic [63:0]       beat_lo, beat_hi;
  logic [PW-1:0]     wp_ext, dist_ext, src_ext;
  logic [AW-1:0]     wp_inc;

  assign dclamp = (dbits_q < 3'd4) ? 3'd4 : ((dbits_q > 3'd6) ? 3'd6 : dbits_q);

  lzx_token_dec u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dec_start),
    .buf_i     (buf_d),
    .cnt_i     (bcnt_d),
    .lmode_i   (lmode_q),
    .dbits_i   (dclamp),
    .done_o    (dec_done),
    .tok_o     (dec_tok),
    .rem_buf_o (dec_rem_buf),
    .rem_cnt_o (dec_rem_cnt)
  );

  lzx_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      beat_lo[8*i +: 8] = beat_q[i];
      beat_hi[8*i +: 8] = beat_q[i+8];
    end
  end

  assign wp_ext   = {1'b0, wp_q};
  assign dist_ext = PW'(dist_q);
  assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                         : (wp_ext + PW'(WINDOW_DEPTH) - dist_ext);
  assign wp_inc   = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign out_free = !ovalid_q || !out_stall_i;
  assign can_push = (fill_q != FILL_W'(BEAT_N)) || out_free;

  always_comb begin
    state_d  = state_q;
    buf_d    = buf_q;
    bcnt_d   = bcnt_q;
    wp_d     = wp_q;
    fin_d    = fin_q;
    fail_d   = fail_q;
    end_d    = end_q;
    err_d    = err_q;
    lmode_d  = lmode_q;
    dbits_d  = dbits_q;
    beat_d   = beat_q;
    fill_d   = fill_q;
    rem_d    = rem_q;
    dist_d   = dist_q;
    lit_d    = lit_q;
    ovalid_d = ovalid_q && out_stall_i;
    olow_d   = olow_q;
    ohigh_d  = ohigh_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    oend_d   = oend_q;
    oerr_d   = oerr_q;
    dec_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = src_ext[AW-1:0];
    ram_wdata = '0;
    push_en   = 1'b0;
    push_byte = '0;

    if (cfg_valid_i) begin
      if (cfg_index_i == REG_LMODE) lmode_d = cfg_data_i[0];
      if (cfg_index_i == REG_DBITS) dbits_d = cfg_data_i;
    end

    case (state_q)
      TS_IDLE: begin
        if (in_valid_i && !(fin_q || fail_q)) begin
          buf_d     = buf_q | (BUF_W'(compressed_byte_i) << bcnt_q);
          bcnt_d    = bcnt_q + CNT_W'(8);
          end_d     = 1'b0;
          err_d     = 1'b0;
          dec_start = 1'b1;
          state_d   = TS_DEC;
        end
      end
      TS_DEC: begin
        if (dec_done) begin
          case (dec_tok.kind)
            TK_LIT: begin
              buf_d   = dec_rem_buf;
              bcnt_d  = dec_rem_cnt;
              lit_d   = dec_tok.lit;
              state_d = TS_LIT;
            end
            TK_COPY: begin
              buf_d   = dec_rem_buf;
              bcnt_d  = dec_rem_cnt;
              rem_d   = dec_tok.len;
              dist_d  = dec_tok.distance;
              state_d = TS_CRD;
            end
            TK_END: begin
              buf_d   = '0;
              bcnt_d  = '0;
              end_d   = 1'b1;
              fin_d   = 1'b1;
              state_d = TS_FIN;
            end
            TK_ERR: begin
              buf_d   = '0;
              bcnt_d  = '0;
              err_d   = 1'b1;
              fail_d  = 1'b1;
              state_d = TS_FIN;
            end
            default: state_d = TS_FIN;
          endcase
        end
      end
      TS_LIT: begin
        if (can_push) begin
          push_en   = 1'b1;
          push_byte = lit_q;
          dec_start = 1'b1;
          state_d   = TS_DEC;
        end
      end
      TS_CRD: begin
        ram_re  = 1'b1;
        state_d = TS_CWR;
      end
      TS_CWR: begin
        if (can_push) begin
          push_en   = 1'b1;
          push_byte = ram_rdata;
          rem_d     = rem_q - 1'b1;
          if (rem_q == LEN_W'(1)) begin
            dec_start = 1'b1;
            state_d   = TS_DEC;
          end else begin
            state_d = TS_CRD;
          end
        end
      end
      TS_FIN: begin
        if (out_free) begin
          if ((fill_q == FILL_W'(BEAT_N)) && (end_q || err_q)) begin
            ovalid_d = 1'b1;
            olow_d   = beat_lo;
            ohigh_d  = beat_hi;
            ocnt_d   = fill_q;
            olast_d  = 1'b0;
            oend_d   = 1'b0;
            oerr_d   = 1'b0;
            fill_d   = '0;
            for (int i = 0; i < BEAT_N; i++) beat_d[i] = '0;
          end else begin
            if ((fill_q != '0) || end_q || err_q) begin
              ovalid_d = 1'b1;
              olow_d   = beat_lo;
              ohigh_d  = beat_hi;
              ocnt_d   = fill_q;
              olast_d  = 1'b1;
              oend_d   = end_q;
              oerr_d   = err_q;
              fill_d   = '0;
              for (int i = 0; i < BEAT_N; i++) beat_d[i] = '0;
            end
            state_d = TS_IDLE;
          end
        end
      end
      default: state_d = TS_IDLE;
    endcase

    // byte into window and beat; a full beat goes out first
    if (push_en) begin
      ram_we    = 1'b1;
      ram_wdata = push_byte;
      wp_d      = wp_inc;
      if (fill_q == FILL_W'(BEAT_N)) begin
        ovalid_d = 1'b1;
        olow_d   = beat_lo;
        ohigh_d  = beat_hi;
        ocnt_d   = fill_q;
        olast_d  = 1'b0;
        oend_d   = 1'b0;
        oerr_d   = 1'b0;
        for (int i = 0; i < BEAT_N; i++) beat_d[i] = '0;
        beat_d[0] = push_byte;
        fill_d    = FILL_W'(1);
      end else begin
        beat_d[fill_q[3:0]] = push_byte;
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= TS_IDLE;
      buf_q    <= '0;
      bcnt_q   <= '0;
      wp_q     <= '0;
      fin_q    <= 1'b0;
      fail_q   <= 1'b0;
      end_q    <= 1'b0;
      err_q    <= 1'b0;
      lmode_q  <= 1'b0;
      dbits_q  <= 3'd6;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < BEAT_N; i++) beat_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      buf_q    <= buf_d;
      bcnt_q   <= bcnt_d;
      wp_q     <= wp_d;
      fin_q    <= fin_d;
      fail_q   <= fail_d;
      end_q    <= end_d;
      err_q    <= err_d;
      lmode_q  <= lmode_d;
      dbits_q  <= dbits_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
      beat_q   <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dist_q  <= dist_d;
    lit_q   <= lit_d;
    olow_q  <= olow_d;
    ohigh_q <= ohigh_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
    oend_q  <= oend_d;
    oerr_q  <= oerr_d;
  end

  assign in_stall_o   = (state_q != TS_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = ovalid_q;
  assign bytes_low_o  = olow_q;
  assign bytes_high_o = ohigh_q;
  assign byte_count_o = ocnt_q;
  assign run_last_o   = olast_q;
  assign stream_end_o = oend_q;
  assign code_error_o = oerr_q;

endmodule
`default_nettype wire
